// ----- sv/c2s_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared types and constants for the column-to-span converter.
// ----------------------------------------------------------------------------
package c2s_pkg;

    localparam int ROWS_DEF = 64;   // default row count (2..64)

    localparam int COL_W  = 10;     // input column field
    localparam int SCOL_W = 9;      // stored / emitted column
    localparam int TOP_W  = 7;      // top field, also holds the empty marker
    localparam int ROW_W  = 6;      // row / bottom field

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [TOP_W-1:0] prev_top;
        logic [ROW_W-1:0] prev_bottom;
        logic [TOP_W-1:0] cur_top;
        logic [ROW_W-1:0] cur_bottom;
    } t_col_word;

    typedef struct packed {
        logic [ROW_W-1:0]  span_row;
        logic [SCOL_W-1:0] span_first;
        logic [SCOL_W-1:0] span_last;
        logic              final_span;
    } t_span_word;

endpackage : c2s_pkg
`default_nettype wire

// ----- sv/c2s_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c2s_out_stage
// Output register for span words; frees itself in the cycle it is taken.
// ----------------------------------------------------------------------------
module c2s_out_stage
    import c2s_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire t_span_word i_word,
    output logic            o_free,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_span_word      o_word
);

    logic       r_valid;
    t_span_word r_word;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

endmodule : c2s_out_stage
`default_nettype wire

// ----- sv/column_to_span_converter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// column_to_span_converter
// Converts a floor/ceiling region given column by column into horizontal
// spans, keeping each row's open span start in a single-port row memory.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | word         | direction
//  ---------+---------------------+--------------+----------
//  column   | i_valid / o_ready   | i_col        | in
//  span     | o_valid / i_ready   | o_span       | out
//
//  Per column the phases close top rows, close bottom rows, open top rows
//  and open bottom rows, one access of the single row-memory port per
//  cycle while no output stall holds the reads. A span's read data is
//  registered, then loaded into the output register once it is free.
//  Reset (synchronous, active low) clears the sequencer and output valid;
//  the row memory is not cleared, its rows are written before being read.
//  A stalled output holds further reads; writes and the next column's
//  accept do not wait on the output.
//
module column_to_span_converter
    import c2s_pkg::*;
#(
    parameter int ROWS = ROWS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_col_word  i_col,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_span_word      o_span
);

    localparam int AW = $clog2(ROWS);

    // sequencer phases
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a column
    localparam logic [2:0] S_TOP  = 3'd1;  // close top rows, ascending
    localparam logic [2:0] S_BOT  = 3'd2;  // close bottom rows, descending
    localparam logic [2:0] S_WTOP = 3'd3;  // open new top rows
    localparam logic [2:0] S_WBOT = 3'd4;  // open new bottom rows

    localparam logic [TOP_W-1:0] ROWS_T = TOP_W'(ROWS);
    localparam logic [TOP_W-1:0] ONE_T  = TOP_W'(1);

    // empty marker: any top at or above ROWS
    function automatic logic [TOP_W-1:0] norm_top(input logic [TOP_W-1:0] v);
        return (v >= ROWS_T) ? ROWS_T : v;
    endfunction

    // bottom saturates at the last row
    function automatic logic [TOP_W-1:0] norm_bot(input logic [ROW_W-1:0] v);
        logic [TOP_W-1:0] w;
        w = {1'b0, v};
        return (w >= ROWS_T) ? (ROWS_T - ONE_T) : w;
    endfunction

    logic [2:0]        r_state, n_state;
    logic [TOP_W-1:0]  r_t1, n_t1, r_b1, n_b1, r_t2, n_t2, r_b2, n_b2;
    logic [SCOL_W-1:0] r_col, n_col, r_last, n_last;
    logic              r_rd_pend, n_rd_pend;
    logic [ROW_W-1:0]  r_pend_row, n_pend_row;
    logic              r_pend_final, n_pend_final;
    logic [SCOL_W-1:0] r_pend_last, n_pend_last;
    logic [SCOL_W-1:0] r_rdata;

    logic [SCOL_W-1:0] mem [ROWS];

    logic              rd_en, wr_en;
    logic [AW-1:0]     mem_addr;
    logic              out_free, out_load, can_issue;
    logic [TOP_W-1:0]  t1_inc, b1_dec;
    logic              top_go, bot_go, wtop_go, wbot_go;
    t_span_word        span_word;

    assign o_ready   = (r_state == S_IDLE);
    assign out_load  = r_rd_pend && out_free;
    assign can_issue = !r_rd_pend || out_free;

    assign t1_inc = r_t1 + ONE_T;
    assign b1_dec = r_b1 - ONE_T;

    assign top_go  = (r_t1 < r_t2) && (r_t1 <= r_b1);
    assign bot_go  = (r_b1 > r_b2) && (r_b1 >= r_t1);
    assign wtop_go = (r_t2 < r_t1) && (r_t2 <= r_b2);
    assign wbot_go = (r_b2 > r_b1) && (r_b2 >= r_t2);

    always_comb begin
        n_state      = r_state;
        n_t1         = r_t1;
        n_b1         = r_b1;
        n_t2         = r_t2;
        n_b2         = r_b2;
        n_col        = r_col;
        n_last       = r_last;
        n_pend_row   = r_pend_row;
        n_pend_final = r_pend_final;
        n_pend_last  = r_pend_last;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        mem_addr     = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_t1    = norm_top(i_col.prev_top);
                    n_b1    = norm_bot(i_col.prev_bottom);
                    n_t2    = norm_top(i_col.cur_top);
                    n_b2    = norm_bot(i_col.cur_bottom);
                    n_col   = i_col.column[SCOL_W-1:0];
                    n_last  = i_col.column[SCOL_W-1:0] - SCOL_W'(1);
                    n_state = S_TOP;
                end
            end
            S_TOP: begin
                if (top_go) begin
                    if (can_issue) begin
                        rd_en        = 1'b1;
                        mem_addr     = r_t1[AW-1:0];
                        n_pend_row   = r_t1[ROW_W-1:0];
                        n_pend_last  = r_last;
                        // last span unless another top row or a bottom row follows
                        n_pend_final = !(((t1_inc < r_t2) && (t1_inc <= r_b1)) ||
                                         ((r_b1 > r_b2) && (r_b1 >= t1_inc)));
                        n_t1         = t1_inc;
                    end
                end else begin
                    n_state = S_BOT;
                end
            end
            S_BOT: begin
                if (bot_go) begin
                    if (can_issue) begin
                        rd_en        = 1'b1;
                        mem_addr     = r_b1[AW-1:0];
                        n_pend_row   = r_b1[ROW_W-1:0];
                        n_pend_last  = r_last;
                        n_pend_final = !((b1_dec > r_b2) && (b1_dec >= r_t1));
                        n_b1         = b1_dec;
                    end
                end else begin
                    n_state = S_WTOP;
                end
            end
            S_WTOP: begin
                if (wtop_go) begin
                    wr_en    = 1'b1;
                    mem_addr = r_t2[AW-1:0];
                    n_t2     = r_t2 + ONE_T;
                end else begin
                    n_state = S_WBOT;
                end
            end
            S_WBOT: begin
                if (wbot_go) begin
                    wr_en    = 1'b1;
                    mem_addr = r_b2[AW-1:0];
                    n_b2     = r_b2 - ONE_T;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (rd_en) begin
            n_rd_pend = 1'b1;
        end else if (out_load) begin
            n_rd_pend = 1'b0;
        end else begin
            n_rd_pend = r_rd_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= n_rd_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1         <= n_t1;
        r_b1         <= n_b1;
        r_t2         <= n_t2;
        r_b2         <= n_b2;
        r_col        <= n_col;
        r_last       <= n_last;
        r_pend_row   <= n_pend_row;
        r_pend_final <= n_pend_final;
        r_pend_last  <= n_pend_last;
    end

    // row start memory: one port, read data registered
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[mem_addr] <= r_col;
        end
        if (rd_en) begin
            r_rdata <= mem[mem_addr];
        end
    end

    // span end travels with its read, so a new column may load r_last
    // while a stalled span still waits
    always_comb begin
        span_word.span_row   = r_pend_row;
        span_word.span_first = r_rdata;
        span_word.span_last  = r_pend_last;
        span_word.final_span = r_pend_final;
    end

    c2s_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_word  (span_word),
        .o_free  (out_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (o_span)
    );

endmodule : column_to_span_converter
`default_nettype wire
